### src/snz_pkg.sv
// Shared types and helpers for the nonzero-first sorting block.
// Used by snz_cell, the top level and the testbench; no dependencies.
package snz_pkg;

    localparam int MAX_COUNT_DEF = 32;
    localparam int DATA_W        = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast item into the sorted row
        logic shift;  // move every entry one cell toward the head
    } t_cell_ctl;

    function automatic logic greater(input t_data a, input t_data b);
        greater = (a > b);
    endfunction

endpackage

### src/snz_cell.sv
// One cell of the insertion chain: holds one sorted entry and its valid bit.
// Depends on snz_pkg.
module snz_cell
    import snz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_data     i_value,
    input  t_data     i_prev_val,
    input  logic      i_prev_valid,
    input  logic      i_prev_gt,
    input  t_data     i_next_val,
    input  logic      i_next_valid,
    output t_data     o_val,
    output logic      o_valid,
    output logic      o_gt
);

    t_data r_val;
    logic  r_valid;
    t_data n_val;
    logic  n_valid;

    // An empty cell acts as +infinity, so an item above every held entry lands at the first empty slot
    assign o_gt    = ~r_valid | greater(r_val, i_value);
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end else if (i_ctl.ins && o_gt) begin
            if (i_prev_gt) begin
                n_val   = i_prev_val;
                n_valid = i_prev_valid;
            end else begin
                n_val   = i_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

### src/sort_nonzero_then_zeros.sv
// Top level of the nonzero-first sorting block: counters, drain control
// and the chain of snz_cell instances. Depends on snz_pkg and snz_cell.
//
// Usage: present an item on i_value / i_last_in and raise start; it is
// taken at a clock edge where start is high and busy is low. While a set
// loads, one item is taken every cycle. Nonzero items are inserted in
// sorted position in the cell chain in the same cycle (all cells compare
// against the broadcast item); zeros are only counted. Items arriving
// once MAX_COUNT are held are dropped and flag overflow for the set.
// The item with i_last_in high closes the set: from the next cycle busy
// is high and one result per cycle is shown with o_valid for exactly one
// cycle (nonzero values ascending, then the zeros), the final one with
// o_last_out. After the last result busy falls, and the next set may
// start in that cycle. The receiver cannot stall; results must be
// taken as they appear. Reset (synchronous, active low) empties the
// chain and clears counts.
module sort_nonzero_then_zeros
    import snz_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    input  logic        i_last_in,
    output logic        o_valid,
    output logic [31:0] o_sorted_value,
    output logic        o_last_out,
    output logic        o_overflow
);

    localparam int CW = $clog2(MAX_COUNT + 1);

    logic [CW-1:0] r_elem_cnt, n_elem_cnt;
    logic [CW-1:0] r_zero_cnt, n_zero_cnt;
    logic [CW-1:0] r_remain,   n_remain;
    logic          r_ovf,      n_ovf;
    logic          r_ovf_out,  n_ovf_out;
    logic          r_busy,     n_busy;

    logic          accept;
    logic          fits;
    logic          is_zero;
    logic [CW:0]   used;
    t_cell_ctl     ctl;

    t_data w_val   [MAX_COUNT];
    logic  w_valid [MAX_COUNT];
    logic  w_gt    [MAX_COUNT];

    assign accept  = start & ~r_busy;
    assign used    = {1'b0, r_elem_cnt} + {1'b0, r_zero_cnt};
    assign fits    = used < (CW+1)'(MAX_COUNT);
    assign is_zero = (i_value == '0);

    assign ctl.ins   = accept & fits & ~is_zero;
    assign ctl.shift = r_busy;

    always_comb begin
        n_elem_cnt = r_elem_cnt;
        n_zero_cnt = r_zero_cnt;
        n_ovf      = r_ovf;
        n_remain   = r_remain;
        n_ovf_out  = r_ovf_out;
        n_busy     = r_busy;
        if (r_busy) begin
            n_remain = r_remain - 1'b1;
            if (r_remain == CW'(1)) begin
                n_busy = 1'b0;
            end
        end else if (accept) begin
            if (!fits) begin
                n_ovf = 1'b1;
            end else if (is_zero) begin
                n_zero_cnt = r_zero_cnt + 1'b1;
            end else begin
                n_elem_cnt = r_elem_cnt + 1'b1;
            end
            if (i_last_in) begin
                n_remain   = n_elem_cnt + n_zero_cnt;
                n_ovf_out  = n_ovf;
                n_busy     = 1'b1;
                n_elem_cnt = '0;
                n_zero_cnt = '0;
                n_ovf      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= '0;
            r_zero_cnt <= '0;
            r_ovf      <= 1'b0;
            r_remain   <= '0;
            r_ovf_out  <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            r_elem_cnt <= n_elem_cnt;
            r_zero_cnt <= n_zero_cnt;
            r_ovf      <= n_ovf;
            r_remain   <= n_remain;
            r_ovf_out  <= n_ovf_out;
            r_busy     <= n_busy;
        end
    end

    for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
        t_data prev_val;
        logic  prev_valid;
        logic  prev_gt;
        t_data next_val;
        logic  next_valid;

        if (g == 0) begin : g_head
            assign prev_val   = '0;
            assign prev_valid = 1'b0;
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign prev_val   = w_val[g-1];
            assign prev_valid = w_valid[g-1];
            assign prev_gt    = w_gt[g-1];
        end

        if (g == MAX_COUNT - 1) begin : g_tail
            assign next_val   = '0;
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_val   = w_val[g+1];
            assign next_valid = w_valid[g+1];
        end

        snz_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_value      (i_value),
            .i_prev_val   (prev_val),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next_val   (next_val),
            .i_next_valid (next_valid),
            .o_val        (w_val[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Once the nonzero entries have left the head, the zeros follow
    assign busy           = r_busy;
    assign o_valid        = r_busy;
    assign o_sorted_value = w_valid[0] ? w_val[0] : '0;
    assign o_last_out     = r_busy & (r_remain == CW'(1));
    assign o_overflow     = r_ovf_out;

endmodule

### src/snz_port_check.sv
// Port-level checker for sort_nonzero_then_zeros, attached by bind.
// Sees only the top-level ports.
module snz_port_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last_in,
    input logic        o_valid,
    input logic        o_last_out,
    input logic        o_overflow
);

    a_valid_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a drain");

    a_last_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |-> o_valid)
        else $error("last marker without a result");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |=> !busy)
        else $error("drain continues after last result");

    a_close_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_in) |=> busy)
        else $error("closing item did not start a drain");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_out) |=> $stable(o_overflow))
        else $error("overflow flag changed within a set");

endmodule

bind sort_nonzero_then_zeros snz_port_check u_snz_port_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_last_in  (i_last_in),
    .o_valid    (o_valid),
    .o_last_out (o_last_out),
    .o_overflow (o_overflow)
);

### sim/sort_nonzero_then_zeros_tb.sv
// Testbench for sort_nonzero_then_zeros: directed, overflow, pressure and random sets.
// Predicts results with its own sorted row; depends on snz_pkg and the block's RTL.
`timescale 1ns / 1ps

module sort_nonzero_then_zeros_tb;
    import snz_pkg::*;

    localparam int CAPACITY   = MAX_COUNT_DEF;
    localparam int STALL_MAX  = 200;   // cycles with no item and no result
    localparam int GAP_MAX    = 20;
    localparam int DRAIN_WAIT = 8;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        ovf;
    } t_sorted_result;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        start     = 1'b0;
    logic [31:0] i_value   = '0;
    logic        i_last_in = 1'b0;
    logic        busy;
    logic        o_valid;
    logic [31:0] o_sorted_value;
    logic        o_last_out;
    logic        o_overflow;

    // predictor state
    t_data          sorted_row[$];
    int             zeros_held;
    logic           dropped_flag;
    t_sorted_result expected_results[$];

    int idle_pct;
    int items_sent;
    int mismatch_count;
    int quiet_cycles;

    sort_nonzero_then_zeros #(.MAX_COUNT(CAPACITY)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the block for one accepted item
    task automatic predict_item(input logic [31:0] v, input logic last);
        int             pos;
        int             total;
        t_data          sv;
        t_sorted_result r;
        sv = v;
        if (sorted_row.size() + zeros_held >= CAPACITY) begin
            dropped_flag = 1'b1;
        end else if (v == '0) begin
            zeros_held++;
        end else begin
            pos = sorted_row.size();
            while (pos > 0 && sorted_row[pos-1] > sv) pos--;
            sorted_row.insert(pos, sv);
        end
        if (last) begin
            total = sorted_row.size() + zeros_held;
            for (int k = 0; k < total; k++) begin
                r.value = (k < sorted_row.size()) ? sorted_row[k] : '0;
                r.last  = (k == total - 1);
                r.ovf   = dropped_flag;
                expected_results.push_back(r);
            end
            sorted_row.delete();
            zeros_held   = 0;
            dropped_flag = 1'b0;
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the item
    task automatic drive_item(input logic [31:0] v, input logic last);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_value   <= v;
        i_last_in <= last;
        do @(posedge i_clk); while (busy);
        items_sent++;
        predict_item(v, last);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1:    v = '0;
            2:       v = $urandom_range(15) - 8;
            3: begin
                case ($urandom_range(3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            4:       v = {{28{$urandom_range(1) == 1}}, 4'($urandom_range(3))};
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)      return $urandom_range(6, 1);
        else if (r < 92) return $urandom_range(20, 7);
        else if (r < 97) return $urandom_range(CAPACITY, 21);
        else             return $urandom_range(CAPACITY + 6, CAPACITY + 1);
    endfunction

    task automatic send_random_set(input int n);
        for (int i = 0; i < n; i++) drive_item(pick_value(), i == n - 1);
    endtask

    task automatic test_directed();
        logic [31:0] mixed[7];
        mixed = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                  32'h1, 32'h0, 32'h5};
        drive_item(32'h8000_0000, 1'b1);
        drive_item(32'h0, 1'b1);
        foreach (mixed[i]) drive_item(mixed[i], i == 6);
        // zeros ahead of a nonzero closing item
        drive_item(32'h0, 1'b0);
        drive_item(32'h0, 1'b0);
        drive_item(-32'sd7, 1'b1);
        // equal values
        drive_item(32'd9, 1'b0);
        drive_item(32'd9, 1'b0);
        drive_item(-32'sd9, 1'b1);
        drive_item(32'd3, 1'b0);
        drive_item(32'h0, 1'b1);
    endtask

    task automatic test_overflow();
        // full store, then a dropped item and a dropped closing item
        for (int i = 0; i < CAPACITY; i++) drive_item(pick_value(), 1'b0);
        drive_item($urandom(), 1'b0);
        drive_item($urandom(), 1'b1);
        // exactly full, no drop
        for (int i = 0; i < CAPACITY; i++) drive_item($urandom(), i == CAPACITY - 1);
        // all zeros past capacity
        for (int i = 0; i <= CAPACITY; i++) drive_item(32'h0, i == CAPACITY);
    endtask

    task automatic test_pressure();
        for (int s = 0; s < 4; s++) begin
            send_random_set($urandom_range(8, 1));
            start <= 1'b0;
            while (expected_results.size() > 0) @(posedge i_clk);
        end
    endtask

    task automatic test_random(input int pct, input int target);
        idle_pct = pct;
        while (items_sent < target) send_random_set(pick_size());
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_sorted_result exp_r;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((start && !busy) || o_valid) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("FAIL sort_nonzero_then_zeros");
                $finish;
            end
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("unexpected result: value %h last %b ovf %b",
                                 o_sorted_value, o_last_out, o_overflow);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_sorted_value !== exp_r.value || o_last_out !== exp_r.last ||
                        o_overflow !== exp_r.ovf) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     exp_r.value, exp_r.last, exp_r.ovf,
                                     o_sorted_value, o_last_out, o_overflow);
                    end
                end
            end
        end
    end

    initial begin
        zeros_held     = 0;
        dropped_flag   = 1'b0;
        items_sent     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_pct       = 31;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_overflow();
        test_pressure();
        test_random(31, 200);
        test_random(70, 320);
        test_random(0, 430);

        start <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS sort_nonzero_then_zeros");
        end else begin
            $display("FAIL sort_nonzero_then_zeros");
        end
        $finish;
    end

endmodule
